// ===== hdl/sswc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswc_pkg
// Types, constants and helpers for the skid-steer wheel command block.
// ----------------------------------------------------------------------------
package sswc_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int RES_W      = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int WIDE_W     = 36;
  localparam int DIV_W      = 34;
  localparam int CNT_W      = 6;

  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
  localparam logic [2:0] REG_HALF_TRACK   = 3'd1;
  localparam logic [2:0] REG_MAX_TORQUE   = 3'd2;
  localparam logic [2:0] REG_MIN_LOWER    = 3'd3;
  localparam logic [2:0] REG_PITCH_LIMIT  = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_POST,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_FWD,
    OP_DIFF,
    OP_TORQ,
    OP_SLV_L,
    OP_SLV_R
  } op_t;

  typedef logic signed [WIDE_W-1:0] wide_t;

  function automatic logic [DIV_W-1:0] mag_div(input wide_t v);
    wide_t a;
    a = v[WIDE_W-1] ? -v : v;
    return a[DIV_W-1:0];
  endfunction

  // Division by five, truncated toward zero. Magnitudes are clamped to 18 bits
  // first; anything above that gives a quotient which saturates regardless.
  function automatic wide_t div5(input wide_t v);
    logic [DIV_W-1:0] a;
    logic [17:0]      x;
    logic [34:0]      p;
    a = mag_div(v);
    x = (a > DIV_W'(18'h3FFFF)) ? 18'h3FFFF : a[17:0];
    p = x * 17'd52429;
    return v[WIDE_W-1] ? -wide_t'(p[34:18]) : wide_t'(p[34:18]);
  endfunction

  function automatic logic [15:0] sat_speed(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (RES_W - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return hi[15:0];
    end else if (v < lo) begin
      return lo[15:0];
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] sat_effort(input wide_t v);
    wide_t hi;
    hi = (wide_t'(1) <<< RES_W) - wide_t'(1);
    if (v > hi) begin
      return hi[15:0];
    end else if (v < 0) begin
      return 16'd0;
    end
    return v[15:0];
  endfunction

  function automatic wide_t slave_speed(input wide_t wanted, input wide_t wanted5,
                                        input logic signed [15:0] meas);
    wide_t m;
    wide_t w;
    m = meas[15] ? -wide_t'(meas) : wide_t'(meas);
    w = wanted[WIDE_W-1] ? -wanted : wanted;
    if (m < w) begin
      if ((m * 5) < w) begin
        return wanted5;
      end
      return wanted[WIDE_W-1] ? -m : m;
    end
    return wanted;
  endfunction

endpackage

// ===== hdl/skid_steer_wheel_command.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skid_steer_wheel_command
// Holds the motion command and derives per-wheel speed and torque commands.
// ----------------------------------------------------------------------------
// One tick is taken per input transfer. A tick without wheel status is
// absorbed without leaving the idle state and gives no result. A tick with
// status runs three divisions on one shared bit-serial divider (forward
// speed, turn term and torque interpolation), each made of a load, 34 steps
// and a store, and then works out the two one-fifth slave floors by
// reciprocal multiplication, each through the load and post states. The
// result is registered and the input is ready again in the same cycle;
// if the previous result has not yet been taken, both wait until it is.
// Configuration writes are taken at any time, but should be made only while
// no tick is in progress.
module skid_steer_wheel_command
  import sswc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // translation, rotation, body_pitch, front_left_speed, front_right_speed,
  // rear_left_speed, rear_right_speed (16 bits each, lowest first)
  input  logic [111:0] in_tdata,
  // new_command, status_available
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // front_left_cmd, front_right_cmd, rear_left_cmd, rear_right_cmd,
  // front_left_effort, front_right_effort, rear_left_effort, rear_right_effort
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] radius_r, half_track_r, max_torque_r, min_lower_r, timeout_r;
  logic [14:0] pitch_limit_r;

  logic signed [15:0] held_trans_r, held_trans_nxt, held_rot_r, held_rot_nxt;
  logic               seen_r, seen_nxt;
  logic [15:0]        ticks_r, ticks_nxt;

  logic signed [15:0] trans_r, rot_r, pitch_r;
  logic signed [15:0] fl_r, fr_r, rl_r, rr_r;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  wide_t fwd_r, diff_r, tq_r, sl5_r, sr5_r;

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [15:0]      rem_r, rem_nxt, den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic  in_fire;
  wide_t wl, wr, quot, lower, prod_d, prod_t;
  logic [16:0] ap, step_sh;
  logic signed [16:0] dlt;
  wide_t fl_c, fr_c, rl_c, rr_c, efl_c, efr_c, erl_c, err_c;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign wl     = fwd_r - diff_r;
  assign wr     = fwd_r + diff_r;
  assign quot   = neg_r ? -wide_t'({2'b00, quo_r}) : wide_t'({2'b00, quo_r});
  assign lower  = wide_t'({1'b0, min_lower_r}) + tq_r;
  assign ap     = pitch_r[15] ? 17'(-{pitch_r[15], pitch_r}) : {1'b0, pitch_r};
  assign dlt    = $signed({1'b0, max_torque_r}) - $signed({1'b0, min_lower_r});
  assign prod_d = wide_t'(rot_r) * wide_t'($signed({1'b0, half_track_r}));
  assign prod_t = wide_t'(dlt) * wide_t'($signed({1'b0, ap}));
  assign step_sh = {rem_r, quo_r[DIV_W-1]};

  always_comb begin
    held_trans_nxt = held_trans_r;
    held_rot_nxt   = held_rot_r;
    seen_nxt       = seen_r;
    ticks_nxt      = ticks_r;
    if (in_tuser[0]) begin
      held_trans_nxt = in_tdata[15:0];
      held_rot_nxt   = in_tdata[31:16];
      seen_nxt       = 1'b1;
      ticks_nxt      = 16'd0;
    end else if (seen_r) begin
      if (ticks_r != 16'hFFFF) begin
        ticks_nxt = ticks_r + 16'd1;
      end
      if (ticks_nxt >= timeout_r) begin
        held_trans_nxt = 16'sd0;
        held_rot_nxt   = 16'sd0;
      end
    end
  end

  always_comb begin
    if (pitch_r > 16'sd0) begin
      rl_c  = wl;
      rr_c  = wr;
      fl_c  = slave_speed(wl, sl5_r, rl_r);
      fr_c  = slave_speed(wr, sr5_r, rr_r);
      erl_c = lower;
      err_c = lower;
      efl_c = wide_t'({1'b0, max_torque_r});
      efr_c = wide_t'({1'b0, max_torque_r});
    end else begin
      fl_c  = wl;
      fr_c  = wr;
      rl_c  = slave_speed(wl, sl5_r, fl_r);
      rr_c  = slave_speed(wr, sr5_r, fr_r);
      efl_c = lower;
      efr_c = lower;
      erl_c = wide_t'({1'b0, max_torque_r});
      err_c = wide_t'({1'b0, max_torque_r});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_tuser[1]) begin
          state_nxt = S_LOAD;
          op_nxt    = OP_FWD;
        end
      end
      S_LOAD: begin
        rem_nxt   = 16'd0;
        cnt_nxt   = CNT_W'(DIV_W - 1);
        den_nxt   = (radius_r == 16'd0) ? 16'd1 : radius_r;
        state_nxt = S_DIV;
        unique case (op_r)
          OP_FWD: begin
            quo_nxt = mag_div(wide_t'(trans_r) <<< 8);
            neg_nxt = trans_r[15];
          end
          OP_DIFF: begin
            quo_nxt = mag_div(prod_d);
            neg_nxt = prod_d[WIDE_W-1];
          end
          OP_TORQ: begin
            quo_nxt = (ap < {2'b00, pitch_limit_r}) ? mag_div(prod_t) : '0;
            neg_nxt = prod_t[WIDE_W-1];
            den_nxt = (pitch_limit_r == 15'd0) ? 16'd1 : {1'b0, pitch_limit_r};
          end
          OP_SLV_L, OP_SLV_R: begin
            state_nxt = S_POST;
          end
          default: begin
            quo_nxt = '0;
          end
        endcase
      end
      S_DIV: begin
        if (step_sh >= {1'b0, den_r}) begin
          rem_nxt = 16'(step_sh - {1'b0, den_r});
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = step_sh[15:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        unique case (op_r)
          OP_FWD:   op_nxt = OP_DIFF;
          OP_DIFF:  op_nxt = OP_TORQ;
          OP_TORQ:  op_nxt = OP_SLV_L;
          OP_SLV_L: op_nxt = OP_SLV_R;
          default:  op_nxt = OP_FWD;
        endcase
        state_nxt = (op_r == OP_SLV_R) ? S_FIN : S_LOAD;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {sat_effort(err_c), sat_effort(erl_c),
                           sat_effort(efr_c), sat_effort(efl_c),
                           sat_speed(rr_c), sat_speed(rl_c),
                           sat_speed(fr_c), sat_speed(fl_c)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      op_r          <= OP_FWD;
      out_valid_r   <= 1'b0;
      held_trans_r  <= 16'sd0;
      held_rot_r    <= 16'sd0;
      seen_r        <= 1'b0;
      ticks_r       <= 16'd0;
      radius_r      <= 16'd64;
      half_track_r  <= 16'd128;
      max_torque_r  <= 16'd2560;
      min_lower_r   <= 16'd512;
      pitch_limit_r <= 15'd2860;
      timeout_r     <= 16'd10;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        held_trans_r <= held_trans_nxt;
        held_rot_r   <= held_rot_nxt;
        seen_r       <= seen_nxt;
        ticks_r      <= ticks_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WHEEL_RADIUS: radius_r      <= cfg_data;
          REG_HALF_TRACK:   half_track_r  <= cfg_data;
          REG_MAX_TORQUE:   max_torque_r  <= cfg_data;
          REG_MIN_LOWER:    min_lower_r   <= cfg_data;
          REG_PITCH_LIMIT:  pitch_limit_r <= cfg_data[14:0];
          REG_TIMEOUT:      timeout_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      trans_r <= held_trans_nxt;
      rot_r   <= held_rot_nxt;
      pitch_r <= in_tdata[47:32];
      fl_r    <= in_tdata[63:48];
      fr_r    <= in_tdata[79:64];
      rl_r    <= in_tdata[95:80];
      rr_r    <= in_tdata[111:96];
    end
    if (state_r == S_POST) begin
      unique case (op_r)
        OP_FWD:   fwd_r  <= quot;
        OP_DIFF:  diff_r <= quot;
        OP_TORQ:  tq_r   <= quot;
        OP_SLV_L: sl5_r  <= div5(wl);
        default:  sr5_r  <= div5(wr);
      endcase
    end
  end

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != 16'd0))
    else $error("divider runs with a zero divisor");

  a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_W'(DIV_W - 1)))
    else $error("divider step count out of range");

  a_busy_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser[1]) |=> !in_tready)
    else $error("input taken again while a tick is in progress");

  a_new_command_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser[0]) |=> (ticks_r == 16'd0 && seen_r))
    else $error("new command did not restart the timeout count");

endmodule

// ===== verif/skid_steer_wheel_command_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skid_steer_wheel_command_chk
// Watches the tick, result and register channels, works out the wheel
// commands each tick with status should give and compares them with the results.
// ----------------------------------------------------------------------------
module skid_steer_wheel_command_chk
  import sswc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct {
    logic [15:0] fl_cmd;
    logic [15:0] fr_cmd;
    logic [15:0] rl_cmd;
    logic [15:0] rr_cmd;
    logic [15:0] fl_eff;
    logic [15:0] fr_eff;
    logic [15:0] rl_eff;
    logic [15:0] rr_eff;
  } wheel_cmds_t;

  wheel_cmds_t wheel_cmds_q[$];

  logic [15:0] radius, track, torque_full, torque_base, tmo;
  logic [14:0] pitch_lim;
  longint      hold_trans, hold_rot;
  bit          cmd_seen;
  int unsigned idle_ticks;

  function automatic longint sx(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint absl(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [15:0] clamp_speed(input longint v);
    longint hi;
    hi = (longint'(1) <<< (RES_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_effort(input longint v);
    longint hi;
    hi = (longint'(1) <<< RES_W) - 1;
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return v[15:0];
  endfunction

  function automatic longint follower_speed(input longint wanted, input longint meas);
    longint m;
    longint w;
    m = absl(meas);
    w = absl(wanted);
    if (m < w) begin
      if (m * 5 < w) return wanted / 5;
      return (wanted < 0) ? -m : m;
    end
    return wanted;
  endfunction

  task automatic predict_tick(input logic [1:0] u, input logic [111:0] d);
    longint      tr, ro, r, fwd, dif, wl, wr, pitch, ap, full, base;
    wheel_cmds_t e;
    if (u[0]) begin
      hold_trans = sx(d[15:0]);
      hold_rot   = sx(d[31:16]);
      cmd_seen   = 1'b1;
      idle_ticks = 0;
    end else if (cmd_seen) begin
      if (idle_ticks < 65535) idle_ticks++;
      if (idle_ticks >= tmo) begin
        hold_trans = 0;
        hold_rot   = 0;
      end
    end
    if (!u[1]) return;
    tr  = cmd_seen ? hold_trans : 0;
    ro  = cmd_seen ? hold_rot : 0;
    r   = (radius == 0) ? 1 : longint'(radius);
    fwd = (tr * 256) / r;
    dif = (ro * longint'(track)) / r;
    wl  = fwd - dif;
    wr  = fwd + dif;
    pitch = sx(d[47:32]);
    ap    = absl(pitch);
    full  = longint'(torque_full);
    base  = longint'(torque_base);
    if (ap < longint'(pitch_lim)) base = base + ((full - base) * ap) / longint'(pitch_lim);
    if (pitch > 0) begin
      e.rl_cmd = clamp_speed(wl);
      e.rr_cmd = clamp_speed(wr);
      e.fl_cmd = clamp_speed(follower_speed(wl, sx(d[95:80])));
      e.fr_cmd = clamp_speed(follower_speed(wr, sx(d[111:96])));
      e.rl_eff = clamp_effort(base);
      e.rr_eff = clamp_effort(base);
      e.fl_eff = clamp_effort(full);
      e.fr_eff = clamp_effort(full);
    end else begin
      e.fl_cmd = clamp_speed(wl);
      e.fr_cmd = clamp_speed(wr);
      e.rl_cmd = clamp_speed(follower_speed(wl, sx(d[63:48])));
      e.rr_cmd = clamp_speed(follower_speed(wr, sx(d[79:64])));
      e.fl_eff = clamp_effort(base);
      e.fr_eff = clamp_effort(base);
      e.rl_eff = clamp_effort(full);
      e.rr_eff = clamp_effort(full);
    end
    wheel_cmds_q.push_back(e);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, exp);
    errors++;
  endtask

  task automatic compare_result(input logic [127:0] d);
    wheel_cmds_t e;
    if (wheel_cmds_q.size() == 0) begin
      $display("%0t unexpected result transfer %h", $realtime, d);
      errors++;
      return;
    end
    e = wheel_cmds_q.pop_front();
    if (d[15:0] !== e.fl_cmd) report("front_left_cmd", d[15:0], e.fl_cmd);
    if (d[31:16] !== e.fr_cmd) report("front_right_cmd", d[31:16], e.fr_cmd);
    if (d[47:32] !== e.rl_cmd) report("rear_left_cmd", d[47:32], e.rl_cmd);
    if (d[63:48] !== e.rr_cmd) report("rear_right_cmd", d[63:48], e.rr_cmd);
    if (d[79:64] !== e.fl_eff) report("front_left_effort", d[79:64], e.fl_eff);
    if (d[95:80] !== e.fr_eff) report("front_right_effort", d[95:80], e.fr_eff);
    if (d[111:96] !== e.rl_eff) report("rear_left_effort", d[111:96], e.rl_eff);
    if (d[127:112] !== e.rr_eff) report("rear_right_effort", d[127:112], e.rr_eff);
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      radius      <= 16'd64;
      track       <= 16'd128;
      torque_full <= 16'd2560;
      torque_base <= 16'd512;
      pitch_lim   <= 15'd2860;
      tmo         <= 16'd10;
      hold_trans  = 0;
      hold_rot    = 0;
      cmd_seen    = 1'b0;
      idle_ticks  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WHEEL_RADIUS: radius <= cfg_data;
          REG_HALF_TRACK:   track <= cfg_data;
          REG_MAX_TORQUE:   torque_full <= cfg_data;
          REG_MIN_LOWER:    torque_base <= cfg_data;
          REG_PITCH_LIMIT:  pitch_lim <= cfg_data[14:0];
          REG_TIMEOUT:      tmo <= cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) compare_result(out_tdata);
      if (in_tvalid && in_tready) predict_tick(in_tuser, in_tdata);
      pending = wheel_cmds_q.size();
    end
  end

endmodule

// ===== verif/skid_steer_wheel_command_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skid_steer_wheel_command_tb
// Drives control ticks and register writes into the wheel command block
// with random gaps and back-pressure, and gives the verdict of the checker.
// ----------------------------------------------------------------------------
module skid_steer_wheel_command_tb;
  import sswc_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  int           errors;
  int           pending;
  int           ready_hold = 0;

  always #5 clk = ~clk;

  skid_steer_wheel_command DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  skid_steer_wheel_command_chk checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Result back-pressure: random stretches of ready and stall.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] r, input logic [15:0] t, input logic [15:0] mx,
                          input logic [15:0] mn, input logic [15:0] pl, input logic [15:0] to);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    write_reg(REG_WHEEL_RADIUS, r);
    write_reg(REG_HALF_TRACK, t);
    write_reg(REG_MAX_TORQUE, mx);
    write_reg(REG_MIN_LOWER, mn);
    write_reg(REG_PITCH_LIMIT, pl);
    write_reg(REG_TIMEOUT, to);
  endtask

  task automatic tick(input bit nc, input bit st, input logic [15:0] tr, input logic [15:0] ro,
                      input logic [15:0] pi, input logic [15:0] fl, input logic [15:0] fr,
                      input logic [15:0] rl, input logic [15:0] rr);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= {st, nc};
    in_tdata  <= {rr, rl, fr, fl, pi, ro, tr};
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rnd_speed();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 8191)) - 4096);
      2: return 16'($signed($urandom_range(0, 511)) - 256);
      3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] rnd_pitch();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd0;
      2: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
      default: return 16'($signed($urandom_range(0, 6000)) - 3000);
    endcase
  endfunction

  task automatic random_ticks(input int n);
    repeat (n) begin
      tick($urandom_range(0, 9) < 3, $urandom_range(0, 9) < 8, rnd_speed(), rnd_speed(),
           rnd_pitch(), rnd_speed(), rnd_speed(), rnd_speed(), rnd_speed());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tick(0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    tick(1, 1, 16'd256, 16'd0, 16'd0, 16'd2000, 16'd2000, 16'd0, 16'd0);
    tick(0, 1, 16'd0, 16'd0, 16'd0, 16'd2000, 16'd2000, 16'd500, 16'd500);
    tick(0, 1, 16'd0, 16'd0, -16'sd100, 16'd100, -16'sd100, 16'd0, 16'd0);
    tick(1, 1, -16'sd256, 16'd64, 16'd1430, 16'd0, 16'd0, 16'd300, -16'sd300);
    tick(0, 1, 16'd0, 16'd0, 16'd2860, 16'd0, 16'd0, -16'sd900, 16'd1200);
    tick(0, 1, 16'd0, 16'd0, 16'd25736, 16'd0, 16'd0, 16'd5000, 16'd5000);
    tick(0, 1, 16'd0, 16'd0, -16'sd25736, 16'h8000, 16'h7fff, 16'd0, 16'd0);
    tick(0, 0, 16'd0, 16'd0, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    tick(1, 1, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    tick(1, 1, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    tick(1, 0, 16'd512, 16'd128, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (9) tick(0, 0, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    tick(0, 1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    tick(0, 1, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd0);
    random_ticks(110);
    set_regs(16'd1, 16'd65535, 16'd65535, 16'd0, 16'd25736, 16'd1);
    random_ticks(110);
    set_regs(16'd65535, 16'd1, 16'd0, 16'd65535, 16'd1, 16'd65535);
    random_ticks(110);
    set_regs(16'd0, 16'd0, 16'd3000, 16'd3500, 16'd0, 16'd0);
    random_ticks(110);
    set_regs(16'd200, 16'd300, 16'd4000, 16'd1000, 16'h7fff, 16'd4);
    random_ticks(110);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
